[sv/cba_pkg.sv]
// cba_pkg: shared types and constants for the cluster bitmap allocator
// no dependencies; used by every module of the block
`default_nettype none

package cba_pkg;

  localparam int MAX_CLUSTERS  = 16384;
  localparam int CLUSTER_BYTES = 2048;
  localparam int CB_SHIFT      = $clog2(CLUSTER_BYTES);
  localparam int WORD_BITS     = 32;
  localparam int WORD_BYTES    = WORD_BITS / 8;
  localparam int MAP_WORDS     = MAX_CLUSTERS / WORD_BITS;
  localparam int ADDR_W        = $clog2(MAP_WORDS);
  localparam int BITSEL_W      = $clog2(WORD_BITS);
  localparam int IDX_W         = 14;
  localparam int COUNT_W       = 15;
  localparam int BYTES_W       = COUNT_W - 3;
  localparam int LIM_W         = COUNT_W + 1;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16384);

  localparam logic [2:0] OP_TEST      = 3'd0;
  localparam logic [2:0] OP_ALLOC     = 3'd1;
  localparam logic [2:0] OP_MARK      = 3'd2;
  localparam logic [2:0] OP_FREE      = 3'd3;
  localparam logic [2:0] OP_MARK_ALL  = 3'd4;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NONE_FREE = 2'd2;

  typedef struct packed {
    logic [2:0]       operation;
    logic [IDX_W-1:0] cluster_index;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             bit_value;
    logic [IDX_W-1:0] allocated_index;
  } out_t;

  typedef struct packed {
    logic capture;
    logic bit_rd;
    logic bit_exe;
    logic init_wr;
    logic fill_wr;
    logic scan_rd;
    logic alloc_commit;
    logic no_free;
  } cmd_t;

  typedef struct packed {
    logic in_idx_ok;
    logic fill_none;
    logic fill_last;
    logic init_last;
    logic scan_found;
    logic scan_last;
  } stat_t;

endpackage

`default_nettype wire

[sv/cba_datapath.sv]
// cba_datapath: bitmap memory, word pointer, scan evaluation and result register
// depends on cba_pkg; driven by cba_ctrl through cmd_t, reports through stat_t
`default_nettype none

module cba_datapath
  import cba_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire in_t                in_data,
  input  wire logic               cfg_wr,
  input  wire logic [COUNT_W-1:0] cfg_data,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  output out_t                    result
);

  function automatic logic [WORD_BITS-1:0] thermo(input logic [LIM_W-1:0] base,
                                                  input logic [LIM_W-1:0] limit);
    logic signed [LIM_W:0]  diff;
    logic [WORD_BITS-1:0]   m;
    diff = $signed({1'b0, limit}) - $signed({1'b0, base});
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = diff > $signed((LIM_W + 1)'(i));
    end
    return m;
  endfunction

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata;

  logic [COUNT_W-1:0]   count;
  logic [ADDR_W-1:0]    ptr;
  logic                 ev_valid;
  logic [ADDR_W-1:0]    ev_word;
  in_t                  req;
  out_t                 res;

  logic [COUNT_W-1:0]   bound;
  logic [COUNT_W-1:0]   covered;
  logic [BYTES_W-1:0]   cov_bytes;
  logic [LIM_W-1:0]     n_sys;
  logic [LIM_W-1:0]     ptr_base;
  logic [LIM_W-1:0]     ev_base;
  logic [WORD_BITS-1:0] ptr_cov;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] free_bits;
  logic                 found;
  logic [BITSEL_W-1:0]  hit_pos;
  logic [IDX_W-1:0]     hit_idx;
  logic                 hit_cov;
  logic [ADDR_W-1:0]    req_word;
  logic [BITSEL_W-1:0]  req_bit;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BYTES-1:0] be;
  logic [ADDR_W-1:0]    raddr;

  assign bound     = (count > COUNT_W'(MAX_CLUSTERS)) ? COUNT_W'(MAX_CLUSTERS) : count;
  assign covered   = {bound[COUNT_W-1:3], 3'b000};
  assign cov_bytes = bound[COUNT_W-1:3];
  assign n_sys     = LIM_W'(({1'b0, cov_bytes} + (BYTES_W + 1)'(CLUSTER_BYTES - 1)) >> CB_SHIFT);
  assign ptr_base  = LIM_W'({ptr, {BITSEL_W{1'b0}}});
  assign ev_base   = LIM_W'({ev_word, {BITSEL_W{1'b0}}});
  assign ptr_cov   = thermo(ptr_base, LIM_W'(covered));

  assign req_word  = req.cluster_index[IDX_W-1:BITSEL_W];
  assign req_bit   = req.cluster_index[BITSEL_W-1:0];

  // first free cluster in the word under evaluation
  assign cand      = thermo(ev_base, LIM_W'(bound)) & ~thermo(ev_base, LIM_W'(1));
  assign free_bits = cand & ~(rdata & thermo(ev_base, LIM_W'(covered)));
  assign found     = |free_bits;

  always_comb begin
    hit_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_pos = BITSEL_W'(i);
      end
    end
  end

  assign hit_idx = {ev_word, hit_pos};
  assign hit_cov = {1'b0, hit_idx} < covered;

  always_comb begin
    stat.in_idx_ok  = {1'b0, in_data.cluster_index} < covered;
    stat.fill_none  = covered == '0;
    stat.fill_last  = (COUNT_W'(ptr_base) + COUNT_W'(WORD_BITS)) >= covered;
    stat.init_last  = ptr == ADDR_W'(MAP_WORDS - 1);
    stat.scan_found = ev_valid && found;
    stat.scan_last  = ev_valid && ((COUNT_W'(ev_base) + COUNT_W'(WORD_BITS)) >= bound);
  end

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = '0;
    be    = '1;
    if (cmd.init_wr) begin
      we = 1'b1;
    end else if (cmd.fill_wr) begin
      we    = 1'b1;
      wdata = (req.operation == OP_MARK_ALL) ? '1 : thermo(ptr_base, n_sys);
      for (int k = 0; k < WORD_BYTES; k++) begin
        be[k] = ptr_cov[8*k];
      end
    end else if (cmd.bit_exe) begin
      we    = (req.operation == OP_MARK) || (req.operation == OP_FREE);
      waddr = req_word;
      wdata = rdata;
      wdata[req_bit] = (req.operation == OP_MARK);
    end else if (cmd.alloc_commit) begin
      we    = hit_cov;
      waddr = ev_word;
      wdata = rdata;
      wdata[hit_pos] = 1'b1;
    end
  end

  assign raddr = cmd.bit_rd ? in_data.cluster_index[IDX_W-1:BITSEL_W] : ptr;

  always_ff @(posedge clk) begin
    for (int k = 0; k < WORD_BYTES; k++) begin
      if (we && be[k]) begin
        mem[waddr][8*k +: 8] <= wdata[8*k +: 8];
      end
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= COUNT_RESET;
      ptr      <= '0;
      ev_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        count <= cfg_data;
      end
      if (cmd.capture) begin
        ptr <= '0;
      end else if (cmd.init_wr || cmd.fill_wr || cmd.scan_rd) begin
        ptr <= ptr + ADDR_W'(1);
      end
      ev_valid <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      ev_word <= ptr;
    end
    if (cmd.capture) begin
      req                 <= in_data;
      res.bit_value       <= 1'b0;
      res.allocated_index <= '0;
      if ((in_data.operation inside {OP_TEST, OP_MARK, OP_FREE}) && !stat.in_idx_ok) begin
        res.status <= ST_RANGE;
      end else begin
        res.status <= ST_OK;
      end
    end
    if (cmd.bit_exe && (req.operation == OP_TEST)) begin
      res.bit_value <= rdata[req_bit];
    end
    if (cmd.alloc_commit) begin
      res.allocated_index <= hit_idx;
    end
    if (cmd.no_free) begin
      res.status <= ST_NONE_FREE;
    end
  end

  assign result = res;

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.init_wr, cmd.fill_wr, cmd.bit_exe, cmd.alloc_commit}))
    else $error("more than one bitmap write command");

  a_commit_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_commit |-> ev_valid && found)
    else $error("allocate committed without a free cluster");

  a_fill_cov: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_wr |-> covered != '0 && ptr_cov[0])
    else $error("fill write outside covered map");

  a_scan_stop: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd |-> !(ev_valid && found))
    else $error("scan kept reading after a hit");

endmodule

`default_nettype wire

[sv/cba_ctrl.sv]
// cba_ctrl: sequencing state machine for the cluster bitmap allocator
// depends on cba_pkg; issues cmd_t to cba_datapath and reads its stat_t
`default_nettype none

module cba_ctrl
  import cba_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [2:0] in_op,
  input  wire logic       out_free,
  input  wire stat_t      stat,
  output cmd_t            cmd,
  output logic            accept,
  output logic            emit
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_BIT  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    accept     = 1'b0;
    emit       = 1'b0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.init_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        accept = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_op inside {OP_TEST, OP_MARK, OP_FREE}) begin
            if (stat.in_idx_ok) begin
              cmd.bit_rd = 1'b1;
              state_next = S_BIT;
            end else begin
              state_next = S_DONE;
            end
          end else if (in_op == OP_ALLOC) begin
            state_next = S_SCAN;
          end else if (in_op inside {OP_MARK_ALL, OP_CLEAR_ALL}) begin
            state_next = stat.fill_none ? S_DONE : S_FILL;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_BIT: begin
        cmd.bit_exe = 1'b1;
        state_next  = S_DONE;
      end
      S_SCAN: begin
        if (stat.scan_found) begin
          cmd.alloc_commit = 1'b1;
          state_next       = S_DONE;
        end else if (stat.scan_last) begin
          cmd.no_free = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (stat.fill_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[sv/cluster_bitmap_allocator_top.sv]
// cluster_bitmap_allocator_top: first-fit cluster allocator over a used/free bitmap
// depends on cba_pkg, cba_ctrl, cba_datapath; holds the result output register
//
//   channel | direction | handshake         | word
//   in      | input     | in_valid/in_stall   | in_t  {operation, cluster_index}
//   out     | output    | out_valid/out_stall | out_t {status, bit_value, allocated_index}
//   cfg     | input     | cfg_valid/cfg_ready | cluster_count, 15 bits
//
// test, mark used and free read the map word, then test or write its bit;
// an index out of range goes straight to the result
// allocate reads one 32-bit map word per cycle until it finds a free cluster or the bound
// mark all and clear all write one word per cycle over the covered part of the map
// after reset a clearing pass runs over the map with in_stall high
// a new word is accepted while the previous result still waits under out_stall
`default_nettype none

module cluster_bitmap_allocator_top
  import cba_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_t                in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_t                    out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [COUNT_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;
  out_t  result;
  logic  accept;
  logic  emit;
  logic  out_free;

  assign in_stall  = !accept;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  cba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .accept   (accept),
    .emit     (emit)
  );

  cba_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb_cluster_bitmap_allocator_top.sv]
// tb_cluster_bitmap_allocator_top: self-checking bench for the cluster bitmap allocator
// keeps its own copy of the usage bitmap and cluster count, predicts every result word
// depends on cba_pkg and cluster_bitmap_allocator_top; random output stalls and input gaps
`timescale 1ns / 1ps

module tb_cluster_bitmap_allocator_top;
  import cba_pkg::*;

  localparam logic [2:0] OP_SPARE6   = 3'd6;
  localparam logic [2:0] OP_SPARE7   = 3'd7;
  localparam int         MAP_BYTES   = MAX_CLUSTERS / 8;
  localparam longint     CYCLE_LIMIT = 3_000_000;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  in_t                in_data   = '0;
  logic               out_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [COUNT_W-1:0] cfg_data  = '0;
  logic               in_stall;
  logic               out_valid;
  out_t               out_data;
  logic               cfg_ready;

  bit          usage_map [MAX_CLUSTERS];
  int unsigned cluster_count = COUNT_RESET;
  out_t        pending_replies [$];
  out_t        head_reply;
  int          mismatch_count = 0;
  bit          idle_en = 1'b1;
  longint      cycle_count = 0;

  cluster_bitmap_allocator_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic out_t apply_request(in_t req);
    out_t        r;
    int unsigned lim;
    int unsigned bound;
    int unsigned c;
    int unsigned n;
    int unsigned idx;
    r     = '0;
    idx   = req.cluster_index;
    lim   = ((cluster_count / 8 > MAP_BYTES) ? MAP_BYTES : cluster_count / 8) * 8;
    bound = (cluster_count > MAX_CLUSTERS) ? MAX_CLUSTERS : cluster_count;
    case (req.operation)
      OP_TEST: begin
        if (idx >= lim) r.status = ST_RANGE;
        else r.bit_value = usage_map[idx];
      end
      OP_ALLOC: begin
        c = 1;
        while (c < bound && c < lim && usage_map[c]) c++;
        if (c >= bound) begin
          r.status = ST_NONE_FREE;
        end else begin
          // a cluster in the uncovered tail is handed out but never marked
          if (c < lim) usage_map[c] = 1'b1;
          r.allocated_index = IDX_W'(c);
        end
      end
      OP_MARK: begin
        if (idx >= lim) r.status = ST_RANGE;
        else usage_map[idx] = 1'b1;
      end
      OP_FREE: begin
        if (idx >= lim) r.status = ST_RANGE;
        else usage_map[idx] = 1'b0;
      end
      OP_MARK_ALL: begin
        for (int unsigned i = 0; i < lim; i++) usage_map[i] = 1'b1;
      end
      OP_CLEAR_ALL: begin
        // clusters holding the map itself stay used
        n = (lim / 8 + CLUSTER_BYTES - 1) / CLUSTER_BYTES;
        for (int unsigned i = 0; i < lim; i++) usage_map[i] = 1'b0;
        for (int unsigned i = 0; i < n && i < lim; i++) usage_map[i] = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input out_t want, input out_t got, input bit orphan);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (orphan)
        $display("cycle %0d: result word with nothing pending: status=%0d bit=%0d index=%0d",
                 cycle_count, got.status, got.bit_value, got.allocated_index);
      else
        $display("cycle %0d: expected status=%0d bit=%0d index=%0d, got status=%0d bit=%0d index=%0d",
                 cycle_count, want.status, want.bit_value, want.allocated_index,
                 got.status, got.bit_value, got.allocated_index);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= idle_en && ($urandom_range(0, 99) < 27);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        note_mismatch('0, out_data, 1'b1);
      end else begin
        head_reply = pending_replies.pop_front();
        if (out_data.status !== head_reply.status ||
            out_data.bit_value !== head_reply.bit_value ||
            out_data.allocated_index !== head_reply.allocated_index)
          note_mismatch(head_reply, out_data, 1'b0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic [2:0] op, input logic [IDX_W-1:0] idx);
    in_t req;
    req.operation     = op;
    req.cluster_index = idx;
    if (idle_en) begin
      while ($urandom_range(0, 99) < 27) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(apply_request(req));
  endtask

  task automatic send_random_word();
    int unsigned r;
    int unsigned hi;
    logic [2:0]  op;
    r = $urandom_range(0, 99);
    if (r < 24) op = OP_TEST;
    else if (r < 48) op = OP_ALLOC;
    else if (r < 60) op = OP_MARK;
    else if (r < 80) op = OP_FREE;
    else if (r < 84) op = OP_MARK_ALL;
    else if (r < 90) op = OP_CLEAR_ALL;
    else if (r < 96) op = OP_ALLOC;
    else if (r < 98) op = OP_SPARE6;
    else op = OP_SPARE7;
    hi = (cluster_count + 8 > MAX_CLUSTERS - 1) ? MAX_CLUSTERS - 1 : cluster_count + 8;
    if ($urandom_range(0, 99) < 70) send_word(op, IDX_W'($urandom_range(0, hi)));
    else send_word(op, IDX_W'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cluster_count(input int unsigned value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= COUNT_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    cluster_count = value;
  endtask

  task automatic test_directed_ops();
    send_word(OP_TEST, 14'd0);
    send_word(OP_TEST, 14'd16383);
    send_word(OP_MARK, 14'd16383);
    send_word(OP_TEST, 14'd16383);
    send_word(OP_FREE, 14'd16383);
    send_word(OP_TEST, 14'd16383);
    send_word(OP_ALLOC, 14'd0);
    send_word(OP_ALLOC, 14'h3fff);
    send_word(OP_MARK, 14'd3);
    send_word(OP_ALLOC, 14'd0);
    send_word(OP_FREE, 14'd2);
    send_word(OP_ALLOC, 14'd0);
    send_word(OP_MARK, 14'h2aaa);
    send_word(OP_TEST, 14'h1555);
    send_word(OP_MARK_ALL, 14'd0);
    send_word(OP_ALLOC, 14'd0);
    send_word(OP_TEST, 14'd100);
    send_word(OP_CLEAR_ALL, 14'd0);
    send_word(OP_TEST, 14'd0);
    send_word(OP_TEST, 14'd1);
    send_word(OP_ALLOC, 14'd0);
    send_word(OP_SPARE6, 14'h3fff);
    send_word(OP_SPARE7, 14'h1234);
  endtask

  task automatic test_tail_and_small_maps();
    write_cluster_count(9);
    send_word(OP_MARK_ALL, 14'd0);
    send_word(OP_ALLOC, 14'd0);
    send_word(OP_ALLOC, 14'd0);
    send_word(OP_TEST, 14'd8);
    send_word(OP_MARK, 14'd8);
    send_word(OP_FREE, 14'd8);
    send_word(OP_FREE, 14'd7);
    send_word(OP_ALLOC, 14'd0);
    send_word(OP_CLEAR_ALL, 14'd0);
    send_word(OP_TEST, 14'd0);
    write_cluster_count(8);
    send_word(OP_MARK_ALL, 14'd0);
    send_word(OP_ALLOC, 14'd0);
    send_word(OP_FREE, 14'd0);
    send_word(OP_ALLOC, 14'd0);
    send_word(OP_TEST, 14'd7);
    send_word(OP_TEST, 14'd8);
    send_word(OP_FREE, 14'd7);
    send_word(OP_ALLOC, 14'd0);
    send_word(OP_ALLOC, 14'd0);
  endtask

  task automatic test_random_counts();
    int unsigned counts [12] = '{8, 12, 16, 23, 64, 100, 255, 1000, 4096, 9999, 16383, 16384};
    foreach (counts[k]) begin
      write_cluster_count(counts[k]);
      repeat (80) send_random_word();
    end
  endtask

  task automatic test_no_idle_stretch();
    write_cluster_count(40);
    idle_en = 1'b0;
    repeat (200) send_random_word();
    settle();
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_tail_and_small_maps();
    test_random_counts();
    test_no_idle_stretch();
    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
